// ===== rtl/dht_pkg.sv =====
`timescale 1ns / 1ps

package dht_pkg;

  // Table geometry
  localparam int NUM_SLOTS    = 13;
  localparam int SECOND_PRIME = 7;
  localparam int KEY_W        = 31;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int CNT_W        = $clog2(NUM_SLOTS + 1);
  localparam int REM2_W       = $clog2(SECOND_PRIME);
  localparam int H2_W         = $clog2(SECOND_PRIME + 1);

  // Key is folded into the remainders one byte per cycle, top byte first
  localparam int HASH_STEPS   = 4;
  localparam int HSTEP_W      = $clog2(HASH_STEPS);

  // Request actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_FOUND    = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic hash_step;
    logic setup;
    logic probe_step;
    logic finish;
  } dht_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;
    logic out_free;
  } dht_stat_t;

  // (r * 256 + b) mod m for r < m <= 15, by eight compare-and-subtract steps
  function automatic logic [3:0] mod_byte(input logic [3:0] r, input logic [7:0] b,
                                          input logic [11:0] m);
    logic [11:0] v;
    logic [11:0] mk;
    v = {r, b};
    for (int k = 7; k >= 0; k--) begin
      mk = m << k;
      if (v >= mk) begin
        v = v - mk;
      end
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/dht_ctrl.sv =====
`timescale 1ns / 1ps

module dht_ctrl
  import dht_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dht_stat_t stat,
  output dht_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HASH  = 2'd1;
  localparam logic [1:0] S_SETUP = 2'd2;
  localparam logic [1:0] S_PROBE = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [HSTEP_W-1:0] step;
  logic [HSTEP_W-1:0] step_next;

  assign s_tready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        step_next = '0;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == HSTEP_W'(HASH_STEPS - 1)) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        // hold on the deciding slot until the output register frees up
        if (stat.done) begin
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== rtl/dht_datapath.sv =====
`timescale 1ns / 1ps

module dht_datapath
  import dht_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dht_cmd_t   cmd,
  output dht_stat_t  stat,
  input  logic [31:0] s_tdata,
  input  logic       s_tuser,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [1:0] m_tuser
);

  // Request registers
  logic              act;
  logic [KEY_W-1:0]  key;
  logic [31:0]       shreg;
  logic [3:0]        rem1;
  logic [REM2_W-1:0] rem2;
  logic [3:0]        rem1_next;
  logic [3:0]        rem2_wide;

  // Probe registers
  logic [SLOT_W-1:0] pos;
  logic [H2_W-1:0]   h2;
  logic [CNT_W-1:0]  idx;
  logic              full;

  // Table store
  logic [KEY_W-1:0]      slot_key [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  slot_used;
  logic [CNT_W-1:0]      count;

  // Output register
  logic              out_valid;
  logic [1:0]        out_status;
  logic [3:0]        out_slot;
  logic [3:0]        out_probes;

  // Probe decision
  logic              done;
  logic              wr_en;
  logic [1:0]        res_status;
  logic [3:0]        res_slot;
  logic [3:0]        res_probes;
  logic [SLOT_W:0]   pos_sum;
  logic [SLOT_W-1:0] pos_next;

  assign rem1_next = mod_byte(rem1, shreg[31:24], 12'(NUM_SLOTS));
  assign rem2_wide = mod_byte(4'(rem2), shreg[31:24], 12'(SECOND_PRIME));

  // Next probe position: one add and a single wrap
  always_comb begin
    pos_sum = {1'b0, pos} + (SLOT_W + 1)'(h2);
    if (pos_sum >= (SLOT_W + 1)'(NUM_SLOTS)) begin
      pos_sum = pos_sum - (SLOT_W + 1)'(NUM_SLOTS);
    end
    pos_next = pos_sum[SLOT_W-1:0];
  end

  // Examine the current slot
  always_comb begin
    done       = 1'b0;
    wr_en      = 1'b0;
    res_status = ST_MISSING;
    res_slot   = '0;
    res_probes = 4'(idx + 1'b1);
    if (act == ACT_INSERT && full) begin
      done       = 1'b1;
      res_status = ST_FULL;
      res_probes = '0;
    end else if (!slot_used[pos]) begin
      done = 1'b1;
      if (act == ACT_INSERT) begin
        wr_en      = 1'b1;
        res_status = ST_INSERTED;
        res_slot   = 4'(pos);
      end
    end else if (act == ACT_SEARCH && slot_key[pos] == key) begin
      done       = 1'b1;
      res_status = ST_FOUND;
      res_slot   = 4'(pos);
    end else if (idx == CNT_W'(NUM_SLOTS - 1)) begin
      // every slot examined
      done       = 1'b1;
      res_status = (act == ACT_INSERT) ? ST_FULL : ST_MISSING;
    end
  end

  assign stat.done     = done;
  assign stat.out_free = !out_valid || m_tready;

  // Request capture, hashing and probe walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= s_tuser;
      key   <= s_tdata[KEY_W-1:0];
      shreg <= {1'b0, s_tdata[KEY_W-1:0]};
      rem1  <= '0;
      rem2  <= '0;
    end
    if (cmd.hash_step) begin
      rem1  <= rem1_next;
      rem2  <= rem2_wide[REM2_W-1:0];
      shreg <= shreg << 8;
    end
    if (cmd.setup) begin
      pos  <= rem1[SLOT_W-1:0];
      h2   <= H2_W'(SECOND_PRIME) - H2_W'(rem2);
      idx  <= '0;
      full <= (count == CNT_W'(NUM_SLOTS));
    end
    if (cmd.probe_step) begin
      pos <= pos_next;
      idx <= idx + 1'b1;
    end
  end

  // Key store, written on a committed insert
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      slot_key[pos] <= key;
    end
  end

  // Occupied flags and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      count     <= '0;
    end else if (cmd.finish && wr_en) begin
      slot_used[pos] <= 1'b1;
      count          <= count + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_probes <= res_probes;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_probes, out_slot};
  assign m_tuser  = out_status;

endmodule

// ===== rtl/double_hash_table_insert_search.sv =====
`timescale 1ns / 1ps

// Open-addressed hash table of 13 slots with double hashing.
// Slave channel s_*: one request per transfer, tuser = action (0 insert,
// 1 search), tdata = key. The block takes a request only while idle.
// Master channel m_*: one result per request, tuser = status (0 inserted,
// 1 full, 2 found, 3 not found), tdata = slot and probe count.
// Sequence: after the request is taken the key is reduced modulo 13 and 7
// one byte per cycle, a setup step follows, then one table slot is examined
// per cycle until the request is decided, 1 to 13 slots in all (none for an
// insert into a full table). The block is idle again in the same cycle in
// which the result becomes valid. The probe walk reads the table through
// its single read port.
// A result waits in an output register; the block takes the next request
// meanwhile and, if the receiver still stalls, holds at its deciding probe.
// Reset marks every slot empty and clears the fill count and both channels.
module double_hash_table_insert_search
  import dht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] key, [31] zero
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] slot, [7:4] probes
  output logic [1:0]  m_tuser    // [1:0] status
);

  dht_cmd_t  cmd;
  dht_stat_t stat;

  dht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dht_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A result is committed only once decided and with room to hold it
  a_finish_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (stat.done && stat.out_free))
    else $error("finish without decision or free output");

  // One request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while busy");

  // A result appears only after a finish
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.finish))
    else $error("result valid without finish");

endmodule
